// ===== rtl/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg: shared definitions of the blit rectangle clipper
// Register indexes, field widths, reset values and beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_CLIP_LEFT     = 3'd4,
        CFG_CLIP_TOP      = 3'd5,
        CFG_CLIP_SPAN_X   = 3'd6,
        CFG_CLIP_SPAN_Y   = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_W = 14;
    localparam int SURF_W     = 13;
    localparam int SPAN_W     = 14;
    localparam int COORD_W    = 14;
    localparam int SIZE_W     = 13;
    localparam int OUT_POS_W  = 12;
    localparam int OUT_SIZE_W = 13;

    // Signed width of the internal arithmetic; covers every intermediate sum.
    localparam int AW = 18;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    localparam logic [SURF_W-1:0] RST_SOURCE_WIDTH  = 13'd320;
    localparam logic [SURF_W-1:0] RST_SOURCE_HEIGHT = 13'd200;
    localparam logic [SURF_W-1:0] RST_TARGET_WIDTH  = 13'd320;
    localparam logic [SURF_W-1:0] RST_TARGET_HEIGHT = 13'd200;
    localparam logic [SPAN_W-1:0] RST_CLIP_SPAN_X   = 14'd320;
    localparam logic [SPAN_W-1:0] RST_CLIP_SPAN_Y   = 14'd200;

    // One request as held in the input register.
    typedef struct packed {
        logic                     whole_source;
        logic [COORD_W-1:0]       req_dst_y;
        logic [COORD_W-1:0]       req_dst_x;
        logic [SIZE_W-1:0]        req_src_h;
        logic [SIZE_W-1:0]        req_src_w;
        logic [COORD_W-1:0]       req_src_y;
        logic [COORD_W-1:0]       req_src_x;
    } req_t;

    // One result as held in the output register.
    typedef struct packed {
        logic                     visible;
        logic [OUT_POS_W-1:0]     mirror_start_col;
        logic [OUT_SIZE_W-1:0]    out_height;
        logic [OUT_SIZE_W-1:0]    out_width;
        logic [OUT_POS_W-1:0]     out_dst_y;
        logic [OUT_POS_W-1:0]     out_dst_x;
        logic [OUT_POS_W-1:0]     out_src_y;
        logic [OUT_POS_W-1:0]     out_src_x;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/blit_rectangle_clipper.sv =====
// ----------------------------------------------------------------------------
// blit_rectangle_clipper: source clamp and destination clip of blit requests
// Takes one blit request per beat and returns one clipped rectangle per beat.
// ----------------------------------------------------------------------------
// Each request beat names a source rectangle (or the whole source surface when
// tuser is set) and a destination position. The rectangle is clamped to the
// source surface, the destination moving by the amount cut from the left or
// top, and is then clipped to the clip rectangle, which is itself bounded by
// the destination surface. Every request gives exactly one result beat, in
// order. The block sustains one request per clock cycle while the result side
// does not stall. A request is held in the input register, and the clipping
// between the input register and the result register is a single pass of adds
// and compares, whose result is captured in the result register and presented
// from there until it is taken. Backpressure on the result side stalls both
// registers together, and a request is still taken while the result register
// holds a beat if the input register is free. Surface sizes above MAX_DIM count
// as MAX_DIM. Configuration writes are taken in any cycle and must only be made
// while no request is in flight.
`default_nettype none

module blit_rectangle_clipper
    import brc_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // Request beats.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0 up: req_src_x[13:0], req_src_y[27:14], req_src_w[40:28],
    // req_src_h[53:41], req_dst_x[67:54], req_dst_y[81:68], zeros[87:82]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: whole_source[0]
    input  wire logic                  s_axis_tuser,

    // Result beats.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata from bit 0 up: out_src_x[11:0], out_src_y[23:12], out_dst_x[35:24],
    // out_dst_y[47:36], out_width[60:48], out_height[73:61],
    // mirror_start_col[85:74], zeros[87:86]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: visible[0]
    output logic                       m_axis_tuser
);

    localparam logic signed [AW-1:0] MAX_DIM_S = AW'(MAX_DIM);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SURF_W-1:0] source_width_reg, source_height_reg;
    logic [SURF_W-1:0] target_width_reg, target_height_reg;
    logic [SURF_W-1:0] clip_left_reg, clip_top_reg;
    logic [SPAN_W-1:0] clip_span_x_reg, clip_span_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
            target_width_reg  <= RST_TARGET_WIDTH;
            target_height_reg <= RST_TARGET_HEIGHT;
            clip_left_reg     <= '0;
            clip_top_reg      <= '0;
            clip_span_x_reg   <= RST_CLIP_SPAN_X;
            clip_span_y_reg   <= RST_CLIP_SPAN_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SURF_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SURF_W-1:0];
                CFG_TARGET_WIDTH:  target_width_reg  <= cfg_data[SURF_W-1:0];
                CFG_TARGET_HEIGHT: target_height_reg <= cfg_data[SURF_W-1:0];
                CFG_CLIP_LEFT:     clip_left_reg     <= cfg_data[SURF_W-1:0];
                CFG_CLIP_TOP:      clip_top_reg      <= cfg_data[SURF_W-1:0];
                CFG_CLIP_SPAN_X:   clip_span_x_reg   <= cfg_data;
                CFG_CLIP_SPAN_Y:   clip_span_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Two-stage pipeline control: input register, then result register.
    // Both move together whenever the result register can take a beat.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    req_t in_req_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    res_t res_next;
    logic advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg.whole_source <= s_axis_tuser;
            in_req_reg.req_src_x    <= s_axis_tdata[13:0];
            in_req_reg.req_src_y    <= s_axis_tdata[27:14];
            in_req_reg.req_src_w    <= s_axis_tdata[40:28];
            in_req_reg.req_src_h    <= s_axis_tdata[53:41];
            in_req_reg.req_dst_x    <= s_axis_tdata[67:54];
            in_req_reg.req_dst_y    <= s_axis_tdata[81:68];
        end
        if (advance && in_valid_reg)
        begin
            out_res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Clipping datapath, all in signed AW-bit arithmetic.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] sw, sh, tw, th;
    logic signed [AW-1:0] sx0, sy0, w0, h0, dx0, dy0;
    logic signed [AW-1:0] sx1, sy1, w1, h1, dx1, dy1;
    logic signed [AW-1:0] w2, h2;
    logic signed [AW-1:0] cl_raw, ct_raw, cr, cb, cl, ct;
    logic signed [AW-1:0] dcol, drow;
    logic signed [AW-1:0] sx3, sy3, w3, h3, dx3, dy3;
    logic signed [AW-1:0] w4, h4;
    logic signed [AW-1:0] mirror;
    logic                 src_ok, vis;

    always_comb
    begin
        // Surface sizes limited to MAX_DIM.
        sw = {{(AW-SURF_W){1'b0}}, source_width_reg};
        sh = {{(AW-SURF_W){1'b0}}, source_height_reg};
        tw = {{(AW-SURF_W){1'b0}}, target_width_reg};
        th = {{(AW-SURF_W){1'b0}}, target_height_reg};
        if (sw > MAX_DIM_S) sw = MAX_DIM_S;
        if (sh > MAX_DIM_S) sh = MAX_DIM_S;
        if (tw > MAX_DIM_S) tw = MAX_DIM_S;
        if (th > MAX_DIM_S) th = MAX_DIM_S;

        if (in_req_reg.whole_source)
        begin
            sx0 = '0;
            sy0 = '0;
            w0  = sw;
            h0  = sh;
        end
        else
        begin
            sx0 = {{(AW-COORD_W){in_req_reg.req_src_x[COORD_W-1]}}, in_req_reg.req_src_x};
            sy0 = {{(AW-COORD_W){in_req_reg.req_src_y[COORD_W-1]}}, in_req_reg.req_src_y};
            w0  = {{(AW-SIZE_W){1'b0}}, in_req_reg.req_src_w};
            h0  = {{(AW-SIZE_W){1'b0}}, in_req_reg.req_src_h};
        end
        dx0 = {{(AW-COORD_W){in_req_reg.req_dst_x[COORD_W-1]}}, in_req_reg.req_dst_x};
        dy0 = {{(AW-COORD_W){in_req_reg.req_dst_y[COORD_W-1]}}, in_req_reg.req_dst_y};

        // A negative source origin trims the rectangle and moves the target.
        if (sx0 < 0)
        begin
            w1  = w0 + sx0;
            dx1 = dx0 - sx0;
            sx1 = '0;
        end
        else
        begin
            w1  = w0;
            dx1 = dx0;
            sx1 = sx0;
        end
        if (sy0 < 0)
        begin
            h1  = h0 + sy0;
            dy1 = dy0 - sy0;
            sy1 = '0;
        end
        else
        begin
            h1  = h0;
            dy1 = dy0;
            sy1 = sy0;
        end
        w2 = (sx1 + w1 > sw) ? sw - sx1 : w1;
        h2 = (sy1 + h1 > sh) ? sh - sy1 : h1;
        src_ok = (w2 > 0) && (h2 > 0);

        // Clip rectangle, bounded by the destination surface.
        cl_raw = {{(AW-SURF_W){clip_left_reg[SURF_W-1]}}, clip_left_reg};
        ct_raw = {{(AW-SURF_W){clip_top_reg[SURF_W-1]}}, clip_top_reg};
        cr = cl_raw + {{(AW-SPAN_W){1'b0}}, clip_span_x_reg};
        cb = ct_raw + {{(AW-SPAN_W){1'b0}}, clip_span_y_reg};
        cl = (cl_raw < 0) ? '0 : cl_raw;
        ct = (ct_raw < 0) ? '0 : ct_raw;
        if (cr > tw) cr = tw;
        if (cb > th) cb = th;

        dcol = cl - dx1;
        drow = ct - dy1;
        if (dx1 < cl)
        begin
            sx3 = sx1 + dcol;
            w3  = w2 - dcol;
            dx3 = cl;
        end
        else
        begin
            sx3 = sx1;
            w3  = w2;
            dx3 = dx1;
        end
        if (dy1 < ct)
        begin
            sy3 = sy1 + drow;
            h3  = h2 - drow;
            dy3 = ct;
        end
        else
        begin
            sy3 = sy1;
            h3  = h2;
            dy3 = dy1;
        end
        w4 = (dx3 + w3 > cr) ? cr - dx3 : w3;
        h4 = (dy3 + h3 > cb) ? cb - dy3 : h3;
        vis = src_ok && (w4 > 0) && (h4 > 0);

        // Mirrored blit reads from the far edge of the clamped source span.
        mirror = (sx1 <<< 1) + w2 - AW'(1) - sx3;
    end

    always_comb
    begin
        res_next = '0;
        if (vis)
        begin
            res_next.visible          = 1'b1;
            res_next.out_src_x        = sx3[OUT_POS_W-1:0];
            res_next.out_src_y        = sy3[OUT_POS_W-1:0];
            res_next.out_dst_x        = dx3[OUT_POS_W-1:0];
            res_next.out_dst_y        = dy3[OUT_POS_W-1:0];
            res_next.out_width        = w4[OUT_SIZE_W-1:0];
            res_next.out_height       = h4[OUT_SIZE_W-1:0];
            res_next.mirror_start_col = mirror[OUT_POS_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.visible;
    assign m_axis_tdata  = {2'b00, out_res_reg.mirror_start_col, out_res_reg.out_height,
                            out_res_reg.out_width, out_res_reg.out_dst_y,
                            out_res_reg.out_dst_x, out_res_reg.out_src_y,
                            out_res_reg.out_src_x};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A hidden result carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invisible result with nonzero fields");

    // A visible result always copies a nonempty area.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (out_res_reg.out_width != '0 && out_res_reg.out_height != '0))
        else $error("visible result with empty area");

    // A request held in the input register during a stall is still there.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled request lost");

    // The input side only refuses a beat while both registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with free room");

    // A request moved on at a free output becomes a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("request dropped between stages");

endmodule

`default_nettype wire

// ===== tb/sv/blit_rectangle_clipper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_rectangle_clipper_tb: self-checking bench for the blit rectangle clipper
// A short directed table of blit requests runs against the reset registers.
// It is followed by randomized requests under a series of register settings,
// with random gaps on the request side and stalls on the result side. Every
// result beat is compared field by field with a predictor kept in the bench.
// ----------------------------------------------------------------------------
module blit_rectangle_clipper_tb;
    import brc_pkg::*;

    localparam int MAX_DIM         = 4096;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 124;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 10;

    // One row of the directed table. When fixed is set, the expected
    // result is the one typed into the row; otherwise the predictor decides.
    typedef struct {
        req_t request;
        bit   fixed;
        res_t result;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Bench copy of the register file.
    logic [SURF_W-1:0] model_source_width  = RST_SOURCE_WIDTH;
    logic [SURF_W-1:0] model_source_height = RST_SOURCE_HEIGHT;
    logic [SURF_W-1:0] model_target_width  = RST_TARGET_WIDTH;
    logic [SURF_W-1:0] model_target_height = RST_TARGET_HEIGHT;
    logic [SURF_W-1:0] model_clip_left     = '0;
    logic [SURF_W-1:0] model_clip_top      = '0;
    logic [SPAN_W-1:0] model_clip_span_x   = RST_CLIP_SPAN_X;
    logic [SPAN_W-1:0] model_clip_span_y   = RST_CLIP_SPAN_Y;

    res_t          clipped_rects_due[$];
    directed_row_t directed_rows[$];
    res_t          beat_result;
    res_t          oldest_due;
    int            mismatch_count  = 0;
    int            results_checked = 0;
    int            visible_seen    = 0;
    int            cycle_count     = 0;
    int            send_idle_pct   = 0;
    int            recv_stall_pct  = 0;
    int            stall_left      = 0;

    blit_rectangle_clipper u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 8 ns clock, low first.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Surface registers above the supported size are treated as that size.
    function automatic int surface_dim(input logic [SURF_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // Mostly short idle spells, with the occasional long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                           : int'($urandom_range(1, 3));
    endfunction

    // Source clamp followed by the destination clip, on plain integers so
    // that no intermediate sum can wrap.
    function automatic res_t predict_clip(input req_t r);
        int   sw, sh, tw, th;
        int   sx, sy, w, h, dx, dy;
        int   left0, width0, cl, ct, cr, cb, mirror;
        res_t o;
        o  = '0;
        sw = surface_dim(model_source_width);
        sh = surface_dim(model_source_height);
        tw = surface_dim(model_target_width);
        th = surface_dim(model_target_height);
        if (r.whole_source)
        begin
            sx = 0;
            sy = 0;
            w  = sw;
            h  = sh;
        end
        else
        begin
            sx = int'($signed(r.req_src_x));
            sy = int'($signed(r.req_src_y));
            w  = int'(r.req_src_w);
            h  = int'(r.req_src_h);
        end
        dx = int'($signed(r.req_dst_x));
        dy = int'($signed(r.req_dst_y));

        // Cut the rectangle to the source surface; the destination follows
        // whatever was cut from the left or top.
        if (sx < 0)
        begin
            w  += sx;
            dx -= sx;
            sx = 0;
        end
        if (sy < 0)
        begin
            h  += sy;
            dy -= sy;
            sy = 0;
        end
        if (sx + w > sw)
            w = sw - sx;
        if (sy + h > sh)
            h = sh - sy;
        if (w <= 0 || h <= 0)
            return o;
        left0  = sx;
        width0 = w;

        // Clip window, bounded by the destination surface.
        cl = int'($signed(model_clip_left));
        ct = int'($signed(model_clip_top));
        cr = cl + int'(model_clip_span_x);
        cb = ct + int'(model_clip_span_y);
        if (cl < 0)
            cl = 0;
        if (ct < 0)
            ct = 0;
        if (cr > tw)
            cr = tw;
        if (cb > th)
            cb = th;

        if (dx < cl)
        begin
            sx += cl - dx;
            w  -= cl - dx;
            dx = cl;
        end
        if (dy < ct)
        begin
            sy += ct - dy;
            h  -= ct - dy;
            dy = ct;
        end
        if (dx + w > cr)
            w = cr - dx;
        if (dy + h > cb)
            h = cb - dy;
        if (w <= 0 || h <= 0)
            return o;

        // A mirrored blit reads the clamped rectangle from its right edge,
        // skipping as many columns as the destination clip took from the left.
        mirror             = left0 + width0 - 1 - (sx - left0);
        o.visible          = 1'b1;
        o.out_src_x        = OUT_POS_W'(sx);
        o.out_src_y        = OUT_POS_W'(sy);
        o.out_dst_x        = OUT_POS_W'(dx);
        o.out_dst_y        = OUT_POS_W'(dy);
        o.out_width        = OUT_SIZE_W'(w);
        o.out_height       = OUT_SIZE_W'(h);
        o.mirror_start_col = OUT_POS_W'(mirror);
        return o;
    endfunction

    function automatic req_t make_request(input bit whole, input int sx, input int sy,
                                          input int w, input int h,
                                          input int dx, input int dy);
        req_t r;
        r.whole_source = whole;
        r.req_src_x    = COORD_W'(sx);
        r.req_src_y    = COORD_W'(sy);
        r.req_src_w    = SIZE_W'(w);
        r.req_src_h    = SIZE_W'(h);
        r.req_dst_x    = COORD_W'(dx);
        r.req_dst_y    = COORD_W'(dy);
        return r;
    endfunction

    // Most requests land on or near the surfaces so that the clamp and clip
    // paths all get exercised; one in ten is raw noise over every bit.
    function automatic req_t random_request();
        int          sw, sh, tw, th, pick;
        logic [95:0] noise;
        sw   = surface_dim(model_source_width);
        sh   = surface_dim(model_source_height);
        tw   = surface_dim(model_target_width);
        th   = surface_dim(model_target_height);
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            noise = {$urandom, $urandom, $urandom};
            return noise[$bits(req_t)-1:0];
        end
        return make_request(pick < 22,
            int'($urandom_range(0, sw + 48)) - 32,
            int'($urandom_range(0, sh + 48)) - 32,
            ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8))
                                        : int'($urandom_range(0, sw + 32)),
            ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8))
                                        : int'($urandom_range(0, sh + 32)),
            int'($urandom_range(0, tw + 64)) - 48,
            int'($urandom_range(0, th + 64)) - 48);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken, with tvalid still high.
    task automatic send_request(input req_t r, input res_t due);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - $bits(req_t) + 1){1'b0}}, r[$bits(req_t)-2:0]};
        s_axis_tuser  <= r.whole_source;
        do
            @(posedge clk);
        while (!s_axis_tready);
        clipped_rects_due.push_back(due);
        @(negedge clk);
    endtask

    // Called at a falling edge; leaves cfg_valid high for a following write.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SOURCE_WIDTH:  model_source_width  = value[SURF_W-1:0];
            CFG_SOURCE_HEIGHT: model_source_height = value[SURF_W-1:0];
            CFG_TARGET_WIDTH:  model_target_width  = value[SURF_W-1:0];
            CFG_TARGET_HEIGHT: model_target_height = value[SURF_W-1:0];
            CFG_CLIP_LEFT:     model_clip_left     = value[SURF_W-1:0];
            CFG_CLIP_TOP:      model_clip_top      = value[SURF_W-1:0];
            CFG_CLIP_SPAN_X:   model_clip_span_x   = value[SPAN_W-1:0];
            CFG_CLIP_SPAN_Y:   model_clip_span_y   = value[SPAN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int due, input int got);
        if (due != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, due, got);
        end
    endtask

    // Result side: random stalls, dropped to none in some phases.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (rst_n && $urandom_range(0, 99) < recv_stall_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare every result beat with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beat_result = {m_axis_tuser, m_axis_tdata[$bits(res_t)-2:0]};
            check_field("tdata pad bits", 0,
                        int'(m_axis_tdata[OUT_DATA_W-1:$bits(res_t)-1]));
            if (clipped_rects_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: result beat with none expected, got visible %0d",
                         $time, beat_result.visible);
            end
            else
            begin
                oldest_due = clipped_rects_due.pop_front();
                results_checked++;
                if (beat_result.visible)
                    visible_seen++;
                check_field("visible", oldest_due.visible, beat_result.visible);
                check_field("out_src_x", oldest_due.out_src_x, beat_result.out_src_x);
                check_field("out_src_y", oldest_due.out_src_y, beat_result.out_src_y);
                check_field("out_dst_x", oldest_due.out_dst_x, beat_result.out_dst_x);
                check_field("out_dst_y", oldest_due.out_dst_y, beat_result.out_dst_y);
                check_field("out_width", oldest_due.out_width, beat_result.out_width);
                check_field("out_height", oldest_due.out_height, beat_result.out_height);
                check_field("mirror_start_col", oldest_due.mirror_start_col,
                            beat_result.mirror_start_col);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, clipped_rects_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] setting [8];
        res_t                  full_surface;
        int                    tw_dim;
        req_t                  next_req;

        // Directed rows; the typed results follow from the reset registers
        // (320x200 surfaces, clip window covering the whole target).
        full_surface = '0;
        full_surface.visible          = 1'b1;
        full_surface.out_width        = OUT_SIZE_W'(320);
        full_surface.out_height       = OUT_SIZE_W'(200);
        full_surface.mirror_start_col = OUT_POS_W'(319);
        directed_rows.push_back('{make_request(1, 0, 0, 0, 0, 0, 0), 1, full_surface});
        // Zero width or zero height is empty.
        directed_rows.push_back('{make_request(0, 0, 0, 0, 10, 0, 0), 1, '0});
        directed_rows.push_back('{make_request(0, 0, 0, 10, 0, 0, 0), 1, '0});
        // Field extremes, all of which clip away completely.
        directed_rows.push_back('{make_request(0, -8192, -8192, 8191, 8191, 8191, 8191),
                                  1, '0});
        directed_rows.push_back('{make_request(0, 8191, 8191, 8191, 8191, 0, 0), 1, '0});
        directed_rows.push_back('{make_request(1, 0, 0, 0, 0, -8192, -8192), 1, '0});
        directed_rows.push_back('{make_request(1, 0, 0, 0, 0, 8191, 8191), 1, '0});
        // Lands just right of the destination surface.
        directed_rows.push_back('{make_request(0, 5, 5, 1, 1, 320, 0), 1, '0});
        // The rest go through the predictor.
        directed_rows.push_back('{make_request(1, 0, 0, 0, 0, 319, 199), 0, '0});
        directed_rows.push_back('{make_request(0, -10, -5, 50, 40, 100, 50), 0, '0});
        directed_rows.push_back('{make_request(0, 10, 10, 100, 100, -20, -30), 0, '0});
        directed_rows.push_back('{make_request(0, 250, 150, 100, 100, 300, 190), 0, '0});
        directed_rows.push_back('{make_request(0, -1, -1, 8191, 8191, -1, -1), 0, '0});
        directed_rows.push_back('{make_request(0, 0, 0, 8191, 8191, 0, 0), 0, '0});
        directed_rows.push_back('{make_request(0, 319, 199, 1, 1, 5, 5), 0, '0});
        directed_rows.push_back('{make_request(1, 0, 0, 0, 0, -1, 0), 0, '0});

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].request,
                         directed_rows[i].fixed ? directed_rows[i].result
                                                : predict_clip(directed_rows[i].request));
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            // Registers only change once every result is back.
            while (clipped_rects_due.size() != 0)
                @(posedge clk);
            @(negedge clk);

            case (p)
                // Empty surfaces and window: nothing can be visible.
                0: foreach (setting[i]) setting[i] = '0;
                // Every field at its top code: oversized surfaces, window
                // starting at the most negative edge.
                1:
                begin
                    foreach (setting[i]) setting[i] = '1;
                    setting[CFG_CLIP_LEFT] = 14'h1000;
                    setting[CFG_CLIP_TOP]  = 14'h1000;
                end
                // One-pixel surfaces.
                2:
                begin
                    foreach (setting[i]) setting[i] = 14'd1;
                    setting[CFG_CLIP_LEFT] = '0;
                    setting[CFG_CLIP_TOP]  = '0;
                end
                // Window starting at the largest positive edge.
                3:
                begin
                    foreach (setting[i]) setting[i] = 14'd4096;
                    setting[CFG_CLIP_LEFT]   = 14'h0FFF;
                    setting[CFG_CLIP_TOP]    = 14'h0FFF;
                    setting[CFG_CLIP_SPAN_X] = 14'd8192;
                    setting[CFG_CLIP_SPAN_Y] = 14'd8192;
                end
                // Largest legal surfaces with the widest window.
                4:
                begin
                    foreach (setting[i]) setting[i] = 14'd4096;
                    setting[CFG_CLIP_LEFT]   = 14'h1000;
                    setting[CFG_CLIP_TOP]    = 14'h1000;
                    setting[CFG_CLIP_SPAN_X] = 14'd8192;
                    setting[CFG_CLIP_SPAN_Y] = 14'd8192;
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                        setting[i] = ($urandom_range(0, 7) == 0)
                                     ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'($urandom_range(1, 4096));
                    tw_dim = surface_dim(setting[CFG_TARGET_WIDTH][SURF_W-1:0]);
                    for (int i = 4; i < 6; i++)
                        setting[i] = ($urandom_range(0, 5) == 0)
                                     ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'(int'($urandom_range(0, 160)) - 64);
                    for (int i = 6; i < 8; i++)
                        setting[i] = ($urandom_range(0, 5) == 0)
                                     ? CFG_DATA_W'($urandom)
                                     : CFG_DATA_W'($urandom_range(0, tw_dim + 128));
                end
            endcase
            for (int i = 0; i < 8; i++)
                write_register(cfg_index_t'(i), setting[i]);
            cfg_valid <= 1'b0;

            // Alternate between smooth streaming and gaps on either side.
            send_idle_pct  = (p % 2 == 1) ? 25 : 0;
            recv_stall_pct = (p % 4 >= 2) ? 30 : 0;

            repeat (ITEMS_PER_PHASE)
            begin
                next_req = random_request();
                send_request(next_req, predict_clip(next_req));
            end
            s_axis_tvalid <= 1'b0;
        end

        while (clipped_rects_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d clip results, %0d of them visible, across %0d register settings",
                 results_checked, visible_seen, PHASES + 1);
        $display("with random request gaps and result stalls; %0d field mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
